FILE: design/plrt_pkg.sv
// ----------------------------------------------------------------------------
// plrt_pkg
// Shared types and constants of the page lock range table.
// ----------------------------------------------------------------------------
package plrt_pkg;

   localparam int DEPTH      = 1024;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_W     = 64 - PAGE_SHIFT;
   localparam logic [63:0] PAGE_MASK = 64'h0000_0000_0000_0fff;
   localparam logic [63:0] LIMIT_NONE = 64'hffff_ffff_ffff_ffff;

   typedef enum logic [2:0] {
      OP_LOCK     = 3'd0,
      OP_UNLOCK   = 3'd1,
      OP_COUNT    = 3'd2,
      OP_LIMIT    = 3'd3,
      OP_LOCK_ALL = 3'd4,
      OP_CLEAR    = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_PERM  = 2'd1,
      ST_NOMEM = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SPAN,
      S_PAGE,
      S_DISPATCH,
      S_READ,
      S_EVAL,
      S_ACC,
      S_MOVE_RD,
      S_MOVE_WR,
      S_SPLIT,
      S_FINISH,
      S_LIM_ADD,
      S_LIM_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] address;
      logic [63:0] length;
      logic [63:0] region_end;
      logic        future_flag;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] byte_count;
      logic        all_locked;
      logic        future_locked;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] lo;
      logic [PAGE_W-1:0] hi;
   } entry_type;

endpackage

FILE: design/plrt_engine.sv
// ----------------------------------------------------------------------------
// plrt_engine
// Range table memory and the sequencer that scans it one entry at a time.
// ----------------------------------------------------------------------------
module plrt_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  plrt_pkg::cmd_type cmd,
   input  logic [63:0]       limit,
   output logic              done_valid,
   input  logic              done_ready,
   output plrt_pkg::rsp_type done
);
   import plrt_pkg::*;

   entry_type         mem [DEPTH];
   entry_type         rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              all_ff, all_in;
   logic              fut_ff, fut_in;
   logic [1:0]        status_ff, status_in;
   logic [63:0]       end_ff, end_in;
   logic              end_c_ff, end_c_in;
   logic [PAGE_W-1:0] lp_ff, lp_in, hp_ff, hp_in;
   logic              span_ok_ff, span_ok_in;
   logic [63:0]       acc_ff, acc_in;
   logic              acc_c_ff, acc_c_in;
   logic [63:0]       ovl_ff, ovl_in;
   logic [63:0]       term_ff, term_in;
   logic              term_ok_ff, term_ok_in;
   logic [63:0]       oterm_ff, oterm_in;
   logic              oterm_ok_ff, oterm_ok_in;
   logic [PAGE_W-1:0] hi_save_ff, hi_save_in;

   logic [64:0]       sum65;
   logic [64:0]       up65;
   logic [PAGE_W-1:0] lo, hi;
   logic              no_overlap, head, tail;
   logic [63:0]       bs, be;
   logic [PAGE_W-1:0] ps, pe;

   assign lo = rd_data_ff.lo;
   assign hi = rd_data_ff.hi;
   assign no_overlap = (hp_ff <= lo) || (lp_ff >= hi);
   assign head = lo < lp_ff;
   assign tail = hp_ff < hi;

   // table memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (cmd_valid) state_in = S_SPAN;
         S_SPAN:     state_in = S_PAGE;
         S_PAGE:     state_in = S_DISPATCH;
         S_DISPATCH: begin
            state_in = S_DONE;
            case (cmd_ff.op)
               OP_LOCK:   if (span_ok_ff) state_in = S_READ;
               OP_UNLOCK: if (span_ok_ff && count_ff != '0) state_in = S_READ;
               OP_COUNT:  if (cmd_ff.region_end > cmd_ff.address && !all_ff) state_in = S_READ;
               OP_LIMIT:  if (limit != LIMIT_NONE && limit != '0 && cmd_ff.length != '0)
                             state_in = S_READ;
               default:   state_in = S_DONE;
            endcase
         end
         S_READ:     state_in = (idx_ff >= count_ff) ? S_FINISH : S_EVAL;
         S_EVAL: begin
            if (cmd_ff.op == OP_COUNT || cmd_ff.op == OP_LIMIT) begin
               state_in = S_ACC;
            end else if (no_overlap) begin
               state_in = S_READ;
            end else if (!head && !tail) begin
               state_in = S_MOVE_RD;
            end else if (head && tail) begin
               state_in = S_SPLIT;
            end else begin
               state_in = S_READ;
            end
         end
         S_ACC:      state_in = S_READ;
         S_MOVE_RD:  state_in = S_MOVE_WR;
         S_MOVE_WR:  state_in = S_READ;
         S_SPLIT:    state_in = S_READ;
         S_FINISH: begin
            if (cmd_ff.op == OP_LIMIT) begin
               state_in = span_ok_ff ? S_LIM_ADD : S_LIM_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LIM_ADD:  state_in = S_LIM_CMP;
         S_LIM_CMP:  state_in = S_DONE;
         S_DONE:     if (done_ready) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      all_in      = all_ff;
      fut_in      = fut_ff;
      status_in   = status_ff;
      end_in      = end_ff;
      end_c_in    = end_c_ff;
      lp_in       = lp_ff;
      hp_in       = hp_ff;
      span_ok_in  = span_ok_ff;
      acc_in      = acc_ff;
      acc_c_in    = acc_c_ff;
      ovl_in      = ovl_ff;
      term_in     = term_ff;
      term_ok_in  = term_ok_ff;
      oterm_in    = oterm_ff;
      oterm_ok_in = oterm_ok_ff;
      hi_save_in  = hi_save_ff;
      rd_addr     = idx_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_W-1:0];
      wr_data     = rd_data_ff;
      sum65       = '0;
      up65        = '0;
      bs          = '0;
      be          = '0;
      ps          = '0;
      pe          = '0;
      case (state_ff)
         // capture the transfer
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in    = cmd;
               idx_in    = '0;
               status_in = ST_OK;
               acc_in    = '0;
               acc_c_in  = 1'b0;
               ovl_in    = '0;
            end
         end
         // byte end of the range
         S_SPAN: begin
            sum65    = {1'b0, cmd_ff.address} + {1'b0, cmd_ff.length};
            end_in   = sum65[63:0];
            end_c_in = sum65[64];
         end
         // round out to pages
         S_PAGE: begin
            up65       = {1'b0, end_ff} + {1'b0, PAGE_MASK};
            lp_in      = cmd_ff.address[63:PAGE_SHIFT];
            hp_in      = up65[63:PAGE_SHIFT];
            span_ok_in = (cmd_ff.length != '0) && !end_c_ff && !up65[64]
                         && (up65[63:PAGE_SHIFT] > cmd_ff.address[63:PAGE_SHIFT]);
         end
         // operations that need no scan
         S_DISPATCH: begin
            case (cmd_ff.op)
               OP_COUNT: begin
                  if (cmd_ff.region_end > cmd_ff.address && all_ff) begin
                     acc_in = cmd_ff.region_end - cmd_ff.address;
                  end
               end
               OP_LIMIT: begin
                  if (limit != LIMIT_NONE && limit == '0) status_in = ST_PERM;
               end
               OP_LOCK_ALL: begin
                  all_in = 1'b1;
                  if (cmd_ff.future_flag) fut_in = 1'b1;
               end
               OP_CLEAR: begin
                  count_in = '0;
                  all_in   = 1'b0;
                  fut_in   = 1'b0;
               end
               default: ;
            endcase
         end
         // look at one entry
         S_EVAL: begin
            case (cmd_ff.op)
               OP_COUNT: begin
                  bs = {lo, {PAGE_SHIFT{1'b0}}};
                  be = {hi, {PAGE_SHIFT{1'b0}}};
                  if (bs < cmd_ff.address) bs = cmd_ff.address;
                  if (be > cmd_ff.region_end) be = cmd_ff.region_end;
                  term_in    = be - bs;
                  term_ok_in = be > bs;
               end
               OP_LIMIT: begin
                  term_in    = {hi - lo, {PAGE_SHIFT{1'b0}}};
                  term_ok_in = 1'b1;
                  ps = (lo > lp_ff) ? lo : lp_ff;
                  pe = (hi < hp_ff) ? hi : hp_ff;
                  oterm_in    = {pe - ps, {PAGE_SHIFT{1'b0}}};
                  oterm_ok_in = (pe > ps) && span_ok_ff;
               end
               default: begin
                  if (no_overlap) begin
                     idx_in = idx_ff + 1'b1;
                  end else if (!head && !tail) begin
                     count_in = count_ff - 1'b1;
                  end else if (head) begin
                     wr_en      = 1'b1;
                     wr_data    = '{lo: lo, hi: lp_ff};
                     hi_save_in = hi;
                     if (!tail) idx_in = idx_ff + 1'b1;
                  end else begin
                     wr_en  = 1'b1;
                     wr_data = '{lo: hp_ff, hi: hi};
                     idx_in = idx_ff + 1'b1;
                  end
               end
            endcase
         end
         // accumulate one entry
         S_ACC: begin
            if (cmd_ff.op == OP_COUNT) begin
               if (term_ok_ff) acc_in = acc_ff + term_ff;
            end else begin
               sum65    = {1'b0, acc_ff} + {1'b0, term_ff};
               acc_in   = sum65[63:0];
               acc_c_in = acc_c_ff | sum65[64];
               if (oterm_ok_ff) ovl_in = ovl_ff + oterm_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         // fetch the last entry into the freed slot
         S_MOVE_RD: rd_addr = count_ff[IDX_W-1:0];
         S_MOVE_WR: wr_en = 1'b1;
         // append the tail of a split entry
         S_SPLIT: begin
            if (count_ff < CNT_W'(DEPTH)) begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IDX_W-1:0];
               wr_data  = '{lo: hp_ff, hi: hi_save_ff};
               count_in = count_ff + 1'b1;
            end else begin
               status_in = ST_FULL;
            end
            idx_in = idx_ff + 1'b1;
         end
         // end of scan
         S_FINISH: begin
            if (cmd_ff.op == OP_LOCK) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = '{lo: lp_ff, hi: hp_ff};
                  count_in = count_ff + 1'b1;
               end else begin
                  status_in = ST_FULL;
               end
            end else if (cmd_ff.op == OP_LIMIT) begin
               term_in = {hp_ff - lp_ff, {PAGE_SHIFT{1'b0}}} - ovl_ff;
            end
         end
         S_LIM_ADD: begin
            sum65    = {1'b0, acc_ff} + {1'b0, term_ff};
            acc_in   = sum65[63:0];
            acc_c_in = acc_c_ff | sum65[64];
         end
         S_LIM_CMP: begin
            if (acc_c_ff || acc_ff > limit) status_in = ST_NOMEM;
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         all_ff   <= 1'b0;
         fut_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         all_ff   <= all_in;
         fut_ff   <= fut_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      end_ff      <= end_in;
      end_c_ff    <= end_c_in;
      lp_ff       <= lp_in;
      hp_ff       <= hp_in;
      span_ok_ff  <= span_ok_in;
      acc_ff      <= acc_in;
      acc_c_ff    <= acc_c_in;
      ovl_ff      <= ovl_in;
      term_ff     <= term_in;
      term_ok_ff  <= term_ok_in;
      oterm_ff    <= oterm_in;
      oterm_ok_ff <= oterm_ok_in;
      hi_save_ff  <= hi_save_in;
   end

   // result
   assign cmd_ready          = (state_ff == S_IDLE);
   assign done_valid         = (state_ff == S_DONE);
   assign done.status        = status_ff;
   assign done.byte_count    = (cmd_ff.op == OP_COUNT) ? acc_ff : '0;
   assign done.all_locked    = all_ff;
   assign done.future_locked = fut_ff;

endmodule

FILE: design/page_lock_range_table.sv
// ----------------------------------------------------------------------------
// page_lock_range_table
// Table of page-aligned locked ranges: lock, unlock, count, limit, lock all, clear.
// ----------------------------------------------------------------------------
// An operation arrives as one transfer on the req_ channel (op in tuser) and
// gives one result transfer on the rsp_ channel. One operation is in work at
// a time. Lock, unlock, region count and limit check scan every stored entry
// through the table memory (one write, one registered read). Lock and unlock
// read each entry, then evaluate it with a trim write-back; a split adds an
// append step and a delete adds a move read and write, after which the moved
// entry is evaluated again. Region count and limit check read, evaluate and
// accumulate each entry. Lock all and clear need no scan. The table holds up
// to 1024 entries.
// The limit register is written through csr_wr_en/csr_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset empties the table (entry count zero), clears both mode flags and sets
// the limit to unlimited; the memory itself is not cleared.
// The result sits in an output register; while the receiver stalls the next
// operation can be accepted and worked, and it waits for the slot to free.
// ----------------------------------------------------------------------------
module page_lock_range_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [199:0] req_tdata,   // address, length, region_end, future_flag, pad
   input  logic [2:0]   req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // status, byte_count, all_locked, future_locked, pad
   input  logic         csr_wr_en,
   input  logic [63:0]  csr_wr_data
);
   import plrt_pkg::*;

   logic [63:0] limit_ff;
   cmd_type     cmd;
   logic        done_valid, done_ready;
   rsp_type     done;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_NONE;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // unpack the request
   assign cmd.op          = req_tuser;
   assign cmd.address     = req_tdata[63:0];
   assign cmd.length      = req_tdata[127:64];
   assign cmd.region_end  = req_tdata[191:128];
   assign cmd.future_flag = req_tdata[192];

   plrt_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (req_tvalid),
      .cmd_ready  (req_tready),
      .cmd        (cmd),
      .limit      (limit_ff),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done       (done)
   );

   // output register
   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.future_locked, rsp_ff.all_locked,
                        rsp_ff.byte_count, rsp_ff.status};

`ifndef SYNTHESIS
   // one operation at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an operation is in work");

   // a finished result always lands in the output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      done_valid && done_ready |=> rsp_valid_ff)
      else $error("finished result not loaded");

   // slot empties after a transfer unless refilled
   a_slot_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tready && !done_valid |=> !rsp_valid_ff)
      else $error("result repeated after transfer");
`endif

endmodule

FILE: verif/page_lock_range_table_tb.sv
// ----------------------------------------------------------------------------
// page_lock_range_table_tb
// Stream-level test of the page lock range table. A queue of operations feeds
// a clocked driver; every accepted transfer runs through a page-table
// predictor and the expected result is checked against the monitored output.
// The limit register is swept through several values between phases.
// ----------------------------------------------------------------------------
module page_lock_range_table_tb;
   import plrt_pkg::*;

   typedef struct {
      op_type      op;
      logic [63:0] address;
      logic [63:0] length;
      logic [63:0] region_end;
      logic        future_flag;
   } lock_cmd;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] byte_count;
      logic        all_locked;
      logic        future_locked;
   } lock_rsp;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [199:0] req_tdata;   // address, length, region_end, future_flag, pad
   logic [2:0]   req_tuser;   // op
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;   // status, byte_count, all_locked, future_locked, pad
   logic         csr_wr_en;
   logic [63:0]  csr_wr_data;

   page_lock_range_table dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // predictor state: page table, modes and byte limit
   logic [63:0] low_pg [DEPTH];
   logic [63:0] high_pg [DEPTH];
   int          n_entries;
   bit          all_mode, future_mode;
   logic [63:0] byte_limit;

   lock_cmd pending_ops[$];
   lock_cmd cur_op;
   lock_rsp expected_rsp[$];
   int      errors, n_sent, n_checked, n_full, n_nomem, n_perm, max_entries;
   bit      calm, hold_go, hold_done;
   int      hold_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // round a byte range out to pages, false when empty or wrapping
   function automatic bit page_span(input logic [63:0] addr, len,
                                    output logic [63:0] lp, hp);
      logic [63:0] fin, up;
      lp = '0;
      hp = '0;
      if (len == 0) return 0;
      fin = addr + len;
      if (fin < addr) return 0;
      up = fin + PAGE_MASK;
      if (up < fin) return 0;
      lp = addr >> PAGE_SHIFT;
      hp = up >> PAGE_SHIFT;
      return hp > lp;
   endfunction

   function automatic void append_span(input logic [63:0] lp, hp);
      low_pg[n_entries] = lp;
      high_pg[n_entries] = hp;
      n_entries++;
      if (n_entries > max_entries) max_entries = n_entries;
   endfunction

   // cut pages out of the table; true if a split tail had no room
   function automatic bit strip_pages(input logic [63:0] lp, hp);
      bit dropped = 0;
      int i = 0;
      logic [63:0] lo, hi;
      bit head, tail;
      while (i < n_entries) begin
         lo = low_pg[i];
         hi = high_pg[i];
         if (hp <= lo || lp >= hi) begin
            i++;
            continue;
         end
         head = lo < lp;
         tail = hp < hi;
         if (!head && !tail) begin
            // whole entry goes, last one moves into the hole
            n_entries--;
            low_pg[i] = low_pg[n_entries];
            high_pg[i] = high_pg[n_entries];
            continue;
         end
         if (head) high_pg[i] = lp;
         else low_pg[i] = hp;
         if (head && tail) begin
            if (n_entries < DEPTH) append_span(hp, hi);
            else dropped = 1;
         end
         i++;
      end
      return dropped;
   endfunction

   function automatic logic [1:0] check_limit(input logic [63:0] addr, len);
      logic [75:0] total = '0;
      logic [63:0] lp, hp, ovl, s, e;
      if (byte_limit == LIMIT_NONE) return ST_OK;
      if (byte_limit == 0) return ST_PERM;
      if (len == 0) return ST_OK;
      for (int i = 0; i < n_entries; i++)
         total += 76'((high_pg[i] - low_pg[i]) << PAGE_SHIFT);
      if (page_span(addr, len, lp, hp)) begin
         ovl = '0;
         for (int i = 0; i < n_entries; i++) begin
            s = low_pg[i] > lp ? low_pg[i] : lp;
            e = high_pg[i] < hp ? high_pg[i] : hp;
            if (e > s) ovl += (e - s) << PAGE_SHIFT;
         end
         total += 76'(((hp - lp) << PAGE_SHIFT) - ovl);
      end
      return (total > {12'd0, byte_limit}) ? ST_NOMEM : ST_OK;
   endfunction

   // apply one operation to the predictor and give its result
   function automatic lock_rsp predict_lock_op(input lock_cmd c);
      lock_rsp r;
      logic [63:0] lp, hp, s, e;
      r.status = ST_OK;
      r.byte_count = '0;
      case (c.op)
         OP_LOCK: begin
            if (page_span(c.address, c.length, lp, hp)) begin
               if (strip_pages(lp, hp)) r.status = ST_FULL;
               if (n_entries < DEPTH) append_span(lp, hp);
               else r.status = ST_FULL;
            end
         end
         OP_UNLOCK: begin
            if (n_entries != 0 && page_span(c.address, c.length, lp, hp))
               if (strip_pages(lp, hp)) r.status = ST_FULL;
         end
         OP_COUNT: begin
            if (c.region_end > c.address) begin
               if (all_mode) r.byte_count = c.region_end - c.address;
               else begin
                  for (int i = 0; i < n_entries; i++) begin
                     s = low_pg[i] << PAGE_SHIFT;
                     e = high_pg[i] << PAGE_SHIFT;
                     if (s < c.address) s = c.address;
                     if (e > c.region_end) e = c.region_end;
                     if (e > s) r.byte_count += e - s;
                  end
               end
            end
         end
         OP_LIMIT: r.status = check_limit(c.address, c.length);
         OP_LOCK_ALL: begin
            if (c.future_flag) future_mode = 1;
            all_mode = 1;
         end
         OP_CLEAR: begin
            n_entries = 0;
            all_mode = 0;
            future_mode = 0;
         end
         default: ;
      endcase
      r.all_locked = all_mode;
      r.future_locked = future_mode;
      return r;
   endfunction

   // request driver: predict on each transfer, then offer the next item
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(predict_lock_op(cur_op));
            n_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
               cur_op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_op.op;
               req_tdata <= {7'd0, cur_op.future_flag, cur_op.region_end,
                             cur_op.length, cur_op.address};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(0, 99) >= 15;
      end
   end

   // response monitor
   always @(posedge clock) begin
      lock_rsp x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $error("result transfer with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            x = expected_rsp.pop_front();
            n_checked++;
            if (x.status == ST_FULL) n_full++;
            if (x.status == ST_NOMEM) n_nomem++;
            if (x.status == ST_PERM) n_perm++;
            if (rsp_tdata[1:0] !== x.status) begin
               $error("status: expected %0d, got %0d", x.status, rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[65:2] !== x.byte_count) begin
               $error("byte_count: expected %h, got %h", x.byte_count, rsp_tdata[65:2]);
               errors++;
            end
            if (rsp_tdata[66] !== x.all_locked) begin
               $error("all_locked: expected %b, got %b", x.all_locked, rsp_tdata[66]);
               errors++;
            end
            if (rsp_tdata[67] !== x.future_locked) begin
               $error("future_locked: expected %b, got %b", x.future_locked, rsp_tdata[67]);
               errors++;
            end
         end
      end
   end

   function automatic lock_cmd mk_op(input op_type op, input logic [63:0] a, l, re,
                                    input logic f);
      lock_cmd c;
      c.op = op;
      c.address = a;
      c.length = l;
      c.region_end = re;
      c.future_flag = f;
      return c;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // random operation, mostly on a small window of pages so ranges overlap
   function automatic lock_cmd random_lock_op();
      lock_cmd c;
      int pick = $urandom_range(0, 99);
      int sel;
      c.op = pick < 32 ? OP_LOCK : pick < 58 ? OP_UNLOCK : pick < 74 ? OP_COUNT :
             pick < 90 ? OP_LIMIT : pick < 95 ? OP_LOCK_ALL : OP_CLEAR;
      sel = $urandom_range(0, 99);
      if (sel < 72) c.address = {52'($urandom_range(0, 255)), 12'($urandom_range(0, 4095))};
      else if (sel < 82) c.address = 64'hffff_ffff_ffff_0000 | 64'($urandom_range(0, 65535));
      else c.address = rand64();
      sel = $urandom_range(0, 99);
      if (sel < 62) c.length = 64'($urandom_range(1, 16 * 4096));
      else if (sel < 70) c.length = '0;
      else if (sel < 85) c.length = rand64();
      else c.length = {32'd0, $urandom()};
      c.region_end = $urandom_range(0, 3) == 0 ? rand64()
                                               : c.address + 64'($urandom_range(0, 1 << 20));
      c.future_flag = 1'($urandom_range(0, 1));
      return c;
   endfunction

   task automatic push_random(input int n);
      repeat (n) pending_ops.push_back(random_lock_op());
   endtask

   // wait until every result is back and the block has gone quiet
   task automatic drain();
      while (pending_ops.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_limit(input logic [63:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      byte_limit = v;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_LOCK;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      n_entries = 0;
      all_mode = 0;
      future_mode = 0;
      byte_limit = LIMIT_NONE;
      calm = 0;
      hold_go = 0;
      hold_done = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed corners at the default unlimited setting
      pending_ops.push_back(mk_op(OP_LOCK, 64'h1000, 64'd0, 0, 0));
      pending_ops.push_back(mk_op(OP_LOCK, '1, 64'd1, 0, 0));
      pending_ops.push_back(mk_op(OP_LOCK, 64'hffff_ffff_ffff_f000, 64'h1000, 0, 0));
      pending_ops.push_back(mk_op(OP_LOCK, 64'hffff_ffff_ffff_e000, 64'h1000, 0, 1));
      pending_ops.push_back(mk_op(OP_LOCK, 64'h10010, 64'h10000, 0, 0));
      pending_ops.push_back(mk_op(OP_UNLOCK, 64'h14000, 64'h1000, 0, 0));
      pending_ops.push_back(mk_op(OP_COUNT, 64'h0, 0, '1, 0));
      pending_ops.push_back(mk_op(OP_UNLOCK, 64'h10000, 64'h4000, 0, 0));
      pending_ops.push_back(mk_op(OP_UNLOCK, 64'h1f000, 64'h8000, 0, 0));
      pending_ops.push_back(mk_op(OP_COUNT, 64'h12345, 0, 64'h12345, 0));
      pending_ops.push_back(mk_op(OP_COUNT, '1, 0, 64'h0, 0));
      pending_ops.push_back(mk_op(OP_LIMIT, 64'h0, 64'h0, 0, 0));
      pending_ops.push_back(mk_op(OP_LOCK, 64'h0, 64'hffff_ffff_ffff_0000, 0, 0));
      pending_ops.push_back(mk_op(OP_LOCK_ALL, 64'h0, 0, 0, 0));
      pending_ops.push_back(mk_op(OP_COUNT, 64'h5, 0, '1, 1));
      pending_ops.push_back(mk_op(OP_LOCK_ALL, 64'h0, 0, 0, 1));
      pending_ops.push_back(mk_op(OP_CLEAR, '1, '1, '1, 1));
      pending_ops.push_back(mk_op(OP_UNLOCK, 64'h0, 64'h1000, 0, 0));
      pending_ops.push_back(mk_op(OP_LOCK, 64'h0, 64'hffff_ffff_ffff_0000, 0, 0));
      drain();

      // forbidden limit, then a near-maximum limit checked against a huge locked range
      write_limit(64'h0);
      pending_ops.push_back(mk_op(OP_LIMIT, 64'h0, 64'h1000, 0, 0));
      pending_ops.push_back(mk_op(OP_LIMIT, 64'h0, 64'h0, 0, 0));
      drain();
      write_limit(64'hffff_ffff_ffff_fffe);
      pending_ops.push_back(mk_op(OP_LIMIT, 64'hffff_ffff_ffff_0000, 64'h8000, 0, 0));
      pending_ops.push_back(mk_op(OP_LIMIT, 64'h0, 64'h0, 0, 0));
      pending_ops.push_back(mk_op(OP_LIMIT, '1, '1, 0, 0));
      pending_ops.push_back(mk_op(OP_CLEAR, 0, 0, 0, 0));
      push_random(120);
      drain();

      // small limit; long response hold-off while requests keep coming
      write_limit(64'h40000);
      hold_go = 1;
      push_random(140);
      drain();

      // random limit, run without idling
      write_limit(rand64());
      calm = 1;
      push_random(100);
      drain();
      calm = 0;
      write_limit({44'd0, 20'($urandom())});
      push_random(100);
      drain();

      write_limit(LIMIT_NONE);
      push_random(100);
      drain();

      $display("covered %0d operations, %0d results checked, table peaked at %0d entries",
               n_sent, n_checked, max_entries);
      $display("status counts: not permitted %0d, out of memory %0d, table full %0d",
               n_perm, n_nomem, n_full);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
